### rtl/bbands_pkg.sv
package bbands_pkg;

  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int BAND_BITS       = 26;
  localparam int WINLEN_BITS     = 9;
  localparam logic [WINLEN_BITS-1:0] WINLEN_RESET = 9'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_SQRT,
    ST_BAND,
    ST_UPPER,
    ST_LOWER
  } bb_state_t;

endpackage

### rtl/sliding_window_bollinger_bands.sv
// A sample that fills the window passes through the ring read, the sum update, the
// products, the difference, the 64-step divider and the 32-step square root (at the
// defaults) before its upper band beat is offered. No new sample is accepted until both
// band beats have been taken, so a result side that holds off stalls the input; a sample
// that does not complete the window passes ring read, ring write and sum update first.
// Reset clears the control state, the sums, the pointer and fill count, and sets
// the window length to 20; the sample ring itself is not cleared.
module sliding_window_bollinger_bands
  import bbands_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: window_length.
  input  logic                   cfg_wen,
  input  logic [WINLEN_BITS-1:0] cfg_wdata,
  // Input beats. tdata: sample. tuser: start_series.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                   s_tuser,
  // Result beats. tdata: band_value, zero padded. tuser: is_lower. tlast: last_of_pair.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NB   = $clog2(WINDOW_MAX + 1);
  localparam int CW   = (NB > WINLEN_BITS) ? NB : WINLEN_BITS;
  localparam int S1W  = SAMPLE_BITS + AW;
  localparam int SQW  = 2 * SAMPLE_BITS;
  localparam int S2W  = SQW + AW;
  localparam int NUMW = 2 * S1W;
  localparam int DW   = 2 * NB;
  localparam int BW   = S1W + 3;

  bb_state_t state, state_next;

  // Configuration and series state.
  logic [WINLEN_BITS-1:0] winlen;
  logic [NB-1:0]          n_eff;
  logic [CW-1:0]          winlen_ext;
  logic [AW-1:0]          wp;
  logic [NB-1:0]          fill;
  logic [NB-1:0]          fill_next;
  logic signed [S1W-1:0]  s1;
  logic [S2W-1:0]         s2;

  // Per-sample working registers.
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] old;
  logic                          have_old;
  logic [SQW-1:0]                sq_x;
  logic [SQW-1:0]                sq_old;
  logic [NUMW-1:0]               n_s2;
  logic [NUMW-1:0]               s1_sq;
  logic [S1W-1:0]                s1_abs;
  logic                          s1_neg;
  logic [NUMW-1:0]               num;
  logic [BAND_BITS-1:0]          band_up;
  logic [BAND_BITS-1:0]          band_lo;

  // The sample ring, one synchronous read port and one write port.
  logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [AW-1:0]          rd_addr;
  logic [NB:0]            wp_ext;

  logic accept;
  logic start_flag;
  logic div_start;
  logic div_done;
  logic [NUMW-1:0] var_q;
  logic [DW-1:0]   var_r;
  logic [DW-1:0]   denom;
  logic [S1W-1:0]  mean_q;
  logic [NB-1:0]   mean_r;
  logic            mean_done;
  logic            sqrt_done;
  logic [S1W-1:0]  sigma;
  logic signed [BW-1:0] mean;
  logic signed [BW-1:0] two_sigma;

  assign accept     = s_tvalid && s_tready;
  assign start_flag = s_tuser;

  // Window lengths below two act as two, above the ring depth as the depth.
  always_comb begin
    winlen_ext = CW'(winlen);
    if (winlen_ext < CW'(2)) begin
      n_eff = NB'(2);
    end else if (winlen_ext > CW'(WINDOW_MAX)) begin
      n_eff = NB'(WINDOW_MAX);
    end else begin
      n_eff = NB'(winlen_ext);
    end
  end

  // The oldest sample sits n entries behind the write pointer, wrapping at the depth.
  always_comb begin
    wp_ext = (NB + 1)'(wp);
    if (wp_ext >= (NB + 1)'(n_eff)) begin
      rd_addr = AW'(wp_ext - (NB + 1)'(n_eff));
    end else begin
      rd_addr = AW'(wp_ext + (NB + 1)'(WINDOW_MAX) - (NB + 1)'(n_eff));
    end
  end

  // Read happens at the accept edge and the write in ST_READ, so a full-depth
  // window reads the old entry before it is overwritten.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= ring[rd_addr];
    end
    if (state == ST_READ) begin
      ring[wp] <= x;
    end
  end

  assign fill_next = (fill < n_eff) ? fill + NB'(1) : n_eff;
  assign denom     = DW'(n_eff) * DW'(n_eff - NB'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = ST_SUM;
      ST_SUM:   state_next = (fill_next < n_eff) ? ST_IDLE : ST_MUL;
      ST_MUL:   state_next = ST_SUB;
      ST_SUB:   state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_SQRT;
      ST_SQRT:  if (sqrt_done) state_next = ST_BAND;
      ST_BAND:  state_next = ST_UPPER;
      ST_UPPER: if (m_tready) state_next = ST_LOWER;
      ST_LOWER: if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    m_tuser  = 1'b0;
    m_tlast  = 1'b0;
    m_tdata  = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_UPPER: begin
        m_tvalid = 1'b1;
        m_tdata  = 32'(band_up);
      end
      ST_LOWER: begin
        m_tvalid = 1'b1;
        m_tuser  = 1'b1;
        m_tlast  = 1'b1;
        m_tdata  = 32'(band_lo);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control state: window length, pointer, fill count and the running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      winlen    <= WINLEN_RESET;
      wp        <= '0;
      fill      <= '0;
      s1        <= '0;
      s2        <= '0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      // The divider start is registered at the same edge as the difference, so
      // the dividers load the numerator of this sample.
      div_start <= (state == ST_SUB);
      if (cfg_wen) begin
        // A new window length starts a new series from the first ring entry.
        winlen <= cfg_wdata;
        wp     <= '0;
        fill   <= '0;
        s1     <= '0;
        s2     <= '0;
      end else begin
        if (accept && start_flag) begin
          fill <= '0;
          s1   <= '0;
          s2   <= '0;
        end
        if (state == ST_READ) begin
          wp <= (wp == AW'(WINDOW_MAX - 1)) ? '0 : wp + AW'(1);
        end
        if (state == ST_SUM) begin
          fill <= fill_next;
          if (have_old) begin
            s1 <= s1 - S1W'(old) + S1W'(x);
            s2 <= s2 - S2W'(sq_old) + S2W'(sq_x);
          end else begin
            s1 <= s1 + S1W'(x);
            s2 <= s2 + S2W'(sq_x);
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == ST_READ) begin
      old      <= ring_rd;
      have_old <= (fill >= n_eff);
      sq_x     <= SQW'($signed(x) * $signed(x));
      sq_old   <= SQW'($signed(ring_rd) * $signed(ring_rd));
    end
    if (state == ST_MUL) begin
      n_s2   <= NUMW'(n_eff * s2);
      s1_abs <= s1[S1W-1] ? S1W'(-s1) : S1W'(s1);
      s1_neg <= s1[S1W-1];
      s1_sq  <= NUMW'((s1[S1W-1] ? S1W'(-s1) : S1W'(s1)) *
                      (s1[S1W-1] ? S1W'(-s1) : S1W'(s1)));
    end
    if (state == ST_SUB) begin
      num <= n_s2 - s1_sq;
    end
    if (state == ST_BAND) begin
      band_up <= BAND_BITS'(mean + two_sigma);
      band_lo <= BAND_BITS'(mean - two_sigma);
    end
  end

  // Floor division of the signed sum: round the magnitude quotient away from zero
  // when the sum is negative and the division leaves a remainder.
  always_comb begin
    if (s1_neg) begin
      mean = -$signed(BW'(mean_q)) - ((mean_r != '0) ? BW'(1) : BW'(0));
    end else begin
      mean = $signed(BW'(mean_q));
    end
    two_sigma = $signed({BW'(sigma)} << 1);
  end

  // Variance divider, n*S2 - S1^2 over n*(n-1).
  bbands_div #(
    .NW (NUMW),
    .DW (DW)
  ) u_var_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (num),
    .divisor   (denom),
    .done      (div_done),
    .quotient  (var_q),
    .remainder (var_r)
  );

  // Mean divider, |S1| over n; it runs alongside and finishes first.
  bbands_div #(
    .NW (S1W),
    .DW (NB)
  ) u_mean_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (s1_abs),
    .divisor   (n_eff),
    .done      (mean_done),
    .quotient  (mean_q),
    .remainder (mean_r)
  );

  bbands_sqrt #(
    .NW (NUMW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (div_done && (var_r == var_r) && !mean_done),
    .radicand (var_q),
    .done     (sqrt_done),
    .root     (sigma)
  );

endmodule

### rtl/bbands_div.sv
module bbands_div #(
  parameter int NW = 64,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   rem_next;
  logic [DW:0]     shifted;
  logic            qbit;
  logic [CNTW-1:0] cnt;
  logic            run;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[NW-1]};
    if (shifted >= {1'b0, divisor}) begin
      qbit     = 1'b1;
      rem_next = DW'(shifted - {1'b0, divisor});
    end else begin
      qbit     = 1'b0;
      rem_next = shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      quo <= {quo[NW-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/bbands_sqrt.sv
module bbands_sqrt #(
  parameter int NW = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   radicand,
  output logic            done,
  output logic [NW/2-1:0] root
);

  localparam int HW   = NW / 2;
  localparam int RW   = HW + 2;
  localparam int CNTW = $clog2(HW + 1);

  logic [NW-1:0]   rad;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   rem_shift;
  logic [RW-1:0]   trial;
  logic [RW-1:0]   rem_next;
  logic [HW-1:0]   rt;
  logic            rbit;
  logic [CNTW-1:0] cnt;
  logic            run;

  // One result bit per step: bring down two radicand bits, try 4*root+1.
  always_comb begin
    rem_shift = {rem[RW-3:0], rad[NW-1:NW-2]};
    trial     = {rt, 2'b01};
    if (rem_shift >= trial) begin
      rbit     = 1'b1;
      rem_next = rem_shift - trial;
    end else begin
      rbit     = 1'b0;
      rem_next = rem_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(HW);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (run) begin
      rad <= {rad[NW-3:0], 2'b00};
      rem <= rem_next;
      rt  <= {rt[HW-2:0], rbit};
    end
  end

  assign root = rt;

endmodule

### tb/sv/tb_sliding_window_bollinger_bands.sv
`default_nettype none

// Band predictor and result store. Every accepted sample is folded into a
// private copy of the window, and the band pair that it causes, if any, is
// queued. Every result beat is then compared with the oldest queued band.
class band_scoreboard;
  longint ring[256];
  int unsigned wr_ptr;
  int unsigned filled;
  longint sum1;
  longint unsigned sum2;
  int unsigned win_reg;
  int errors;
  logic [31:0] band_q[$];
  bit lower_q[$];
  bit last_q[$];

  function new();
    win_reg = 20;
    errors = 0;
    clear_series();
  endfunction

  function void clear_series();
    wr_ptr = 0;
    filled = 0;
    sum1 = 0;
    sum2 = 0;
  endfunction

  // A write to the window length always starts a new series.
  function void set_window(int unsigned v);
    win_reg = v & 9'h1FF;
    clear_series();
  endfunction

  function int pending();
    return band_q.size();
  endfunction

  // Appends one expected band beat at the tail of the queues.
  function void enqueue(logic [31:0] band, bit is_low, bit is_last);
    band_q.insert(band_q.size(), band);
    lower_q.insert(lower_q.size(), is_low);
    last_q.insert(last_q.size(), is_last);
  endfunction

  function longint unsigned int_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function void note_sample(logic [23:0] raw, bit restart);
    int unsigned n;
    longint x;
    longint old;
    longint mean;
    longint sigma;
    longint upper;
    longint lower;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned spread;
    n = win_reg;
    // Lengths 0 and 1 behave as 2, anything past the ring size as the ring size.
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    x = longint'($signed(raw));
    if (restart) begin
      filled = 0;
      sum1 = 0;
      sum2 = 0;
    end
    if (filled >= n) begin
      old = ring[(wr_ptr + 256 - n) % 256];
      sum1 = sum1 - old;
      sum2 = sum2 - longint'(old * old);
    end
    ring[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % 256;
    sum1 = sum1 + x;
    sum2 = sum2 + longint'(x * x);
    if (filled < n) filled++;
    if (filled < n) return;
    mean = sum1 / longint'(n);
    if ((sum1 % longint'(n)) != 0 && sum1 < 0) mean = mean - 1;
    mag = (sum1 < 0) ? longint'(-sum1) : sum1;
    num = longint'(n) * sum2 - mag * mag;
    spread = num / (longint'(n) * longint'(n - 1));
    sigma = int_root(spread);
    upper = mean + 2 * sigma;
    lower = mean - 2 * sigma;
    enqueue({6'b0, upper[25:0]}, 1'b0, 1'b0);
    enqueue({6'b0, lower[25:0]}, 1'b1, 1'b1);
  endfunction

  function void check_beat(logic [31:0] data, logic user, logic last);
    logic [31:0] want_band;
    bit want_lower;
    bit want_last;
    if (band_q.size() == 0) begin
      $display("%0t: unexpected band beat data=%h user=%b last=%b", $time, data, user, last);
      errors++;
      return;
    end
    want_band = band_q.pop_front();
    want_lower = lower_q.pop_front();
    want_last = last_q.pop_front();
    if (data !== want_band) begin
      $display("%0t: band_value expected %h actual %h", $time, want_band, data);
      errors++;
    end
    if (user !== want_lower) begin
      $display("%0t: is_lower expected %b actual %b", $time, want_lower, user);
      errors++;
    end
    if (last !== want_last) begin
      $display("%0t: last_of_pair expected %b actual %b", $time, want_last, last);
      errors++;
    end
  endfunction
endclass

module tb_sliding_window_bollinger_bands;
  timeunit 1ns;
  timeprecision 1ps;
  import bbands_pkg::*;

  // The run is cut off at this many cycles, which is ample for the roughly
  // 1300 samples of a correct run, stalls included.
  localparam int CYCLE_LIMIT = 2000000;
  // Quiet cycles after the last band before the window length is touched.
  localparam int SETTLE_CYCLES = 200;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [WINLEN_BITS-1:0] cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [31:0]            m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  band_scoreboard bands = new();

  int cycle_count = 0;
  // When set, the receiver drops ready for a long stretch so that the block
  // backs up and stalls its input. The receiver runs the hold-off only once.
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  // Neither side throttles at random while the cycle count is inside this stretch.
  bit calm;

  sliding_window_bollinger_bands u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign calm = (cycle_count >= 30000) && (cycle_count < 50000);

  // Watchdog. A hung block or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver. Ready drops at random about 11 percent of the time, except in the calm
  // stretch, and stays low for the whole hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 600;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 11);
    end
  end

  // Every result beat is checked on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) bands.check_beat(m_tdata, m_tuser, m_tlast);
  end

  // Offer one sample and hold it until the block takes it. A random gap may
  // come first; valid is only lowered on a cycle where no beat follows.
  task automatic send_sample(logic [23:0] value, bit restart);
    int gap;
    if (!calm && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    bands.note_sample(value, restart);
  endtask

  // Stop offering, wait until every band has come back and the block has
  // had time to finish any sample that caused no band.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bands.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The window length is only changed while the block is idle.
  task automatic write_window(int unsigned length);
    drain_results();
    cfg_wen <= 1'b1;
    cfg_wdata <= length[WINLEN_BITS-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    bands.set_window(length);
    @(posedge clk);
  endtask

  // Most samples wander around a price level so the bands are meaningful;
  // the rest are drawn from the whole code range to exercise every bit.
  // Restarts come now and then so that partly filled series are covered.
  task automatic run_series(int count, int restart_pct);
    int level;
    int step;
    logic [23:0] value;
    level = $urandom_range(0, 4000000) - 2000000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        step = $urandom_range(0, 2000) - 1000;
        level = level + step;
        value = level[23:0];
      end else begin
        value = 24'($urandom());
      end
      send_sample(value, $urandom_range(99) < restart_pct);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length of 20: fill one window and run a little past it.
    run_series(30, 0);

    // Shortest window with the extremes of the sample range, a flat series
    // where sigma is zero, and restarts that break the fill.
    write_window(2);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h123456, 1'b1);
    send_sample(24'hEDCBAA, 1'b0);

    // Lengths 0 and 1 both act as the shortest window.
    write_window(0);
    run_series(40, 5);
    write_window(1);
    run_series(40, 5);

    // Short window with the receiver holding off, so the block backs up.
    write_window(3);
    hold_request = 1'b1;
    run_series(120, 3);

    write_window(7);
    run_series(100, 3);

    write_window(20);
    run_series(100, 2);

    // Full ring, then lengths past it that clamp to the ring size.
    write_window(256);
    run_series(300, 0);
    write_window(300);
    run_series(270, 0);
    write_window(511);
    // A full window of extreme codes drives the sum of squares to its largest.
    for (int i = 0; i < 260; i++) send_sample((i % 2) ? 24'h800000 : 24'h7FFFFF, 1'b0);

    drain_results();
    if (bands.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

### files.f
rtl/bbands_pkg.sv
rtl/bbands_div.sv
rtl/bbands_sqrt.sv
rtl/sliding_window_bollinger_bands.sv
tb/sv/tb_sliding_window_bollinger_bands.sv
